[rtl/core/ict_pkg.sv]
// Package for the interval coverage tracker: item word types, node codes
// and tree size constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ict_pkg;
  localparam int unsigned CoordBits = 10;

  localparam logic [1:0] ModeAdd    = 2'd0;
  localparam logic [1:0] ModeRemove = 2'd1;
  localparam logic [1:0] ModeQuery  = 2'd2;
  localparam logic [1:0] ModeUnused = 2'd3;

  localparam logic [1:0] TagNone  = 2'd0;
  localparam logic [1:0] TagSet   = 2'd1;
  localparam logic [1:0] TagClear = 2'd2;

  typedef struct packed {
    logic [1:0]           mode;
    logic [CoordBits-1:0] left;
    logic [CoordBits:0]   right;
  } item_t;

  typedef struct packed {
    logic answer;
    logic error;
  } result_t;
endpackage
`default_nettype wire

[rtl/core/ict_ram.sv]
// Generic simple dual-port RAM with registered read, one write port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ict_ram #(
  parameter int unsigned Width = 3,
  parameter int unsigned Depth = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[rtl/core/interval_coverage_tracker_core.sv]
// Interval coverage tracker: segment tree with lazy set/clear tags in one RAM.
// Reset is asynchronous, active low; a clearing pass over all 2^(COORD_BITS+1) RAM words
// follows it. A node inside the interval is read and then written or tested; a node it
// splits is read, its tag is pushed to both children when it has one, and on the way back
// both children are re-read and the node is written back, all through the one RAM. Bad
// intervals and unused modes go to done. One word at a time; strobe is one cycle, no stall.
`timescale 1ns / 1ps
`default_nettype none
module interval_coverage_tracker_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire ict_pkg::item_t  item_i,
  output logic                 busy_o,
  output logic                 done_o,
  output ict_pkg::result_t     result_o
);
  localparam int unsigned CoordBits = ict_pkg::CoordBits;
  localparam int unsigned AW = CoordBits + 1;       // node address width
  localparam int unsigned DW = CoordBits + 1;       // stack depth (levels)
  localparam int unsigned SW = $clog2(DW + 1);
  localparam logic [AW:0] NodeCount = {1'b1, {AW{1'b0}}};
  localparam logic [CoordBits:0] Space = {1'b1, {CoordBits{1'b0}}};

  // states
  localparam logic [3:0] StClr   = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StVisit = 4'd2;  // issue read of current node
  localparam logic [3:0] StEval  = 4'd3;  // node word available
  localparam logic [3:0] StPushL = 4'd4;  // write left child
  localparam logic [3:0] StPushR = 4'd5;  // write right child
  localparam logic [3:0] StRdL   = 4'd6;  // rebuild: read left child
  localparam logic [3:0] StRdR   = 4'd7;  // rebuild: read right child
  localparam logic [3:0] StWrN   = 4'd8;  // rebuild: write node
  localparam logic [3:0] StRet   = 4'd9;  // return to parent
  localparam logic [3:0] StDone  = 4'd10;

  logic [3:0] st_q, st_d;
  logic [AW:0] clr_q, clr_d;
  // current node and its span, measured as level (0 root) and start
  logic [AW-1:0] node_q, node_d;
  logic [SW-1:0] lvl_q, lvl_d;
  logic [1:0] mode_q, mode_d;
  logic [CoordBits-1:0] lo_q, lo_d, hi_q, hi_d;
  logic past_q, past_d;
  logic ans_q, ans_d, err_q, err_d, lcov_q, lcov_d;
  // per-level phase: 0 went left next, 1 went right next, 2 rebuilding
  logic [1:0] ph_q [DW], ph_d [DW];

  // RAM port
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [2:0] wdata, rdata;

  ict_ram #(.Width(3), .Depth(1 << AW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // span of current node: start = node bits below leading one, shifted
  logic [CoordBits-1:0] s_v, e_v, mid_v, span_m;
  logic [SW-1:0] sh;
  always_comb begin
    sh     = SW'(CoordBits) - lvl_q;
    span_m = CoordBits'((({{CoordBits{1'b0}}, 1'b1} << sh) - 1'b1));
    s_v    = CoordBits'(node_q << sh);
    e_v    = s_v | span_m;
    mid_v  = s_v | (span_m >> 1);
  end

  // parent of the current node needs the right branch?
  logic [CoordBits-1:0] pmid;
  logic [SW-1:0] psh;
  always_comb begin
    psh  = SW'(CoordBits) - lvl_q + 1'b1;
    pmid = CoordBits'(({1'b0, node_q} >> 1) << psh) |
           CoordBits'((({{CoordBits{1'b0}}, 1'b1} << psh) - 1'b1) >> 1);
  end
  wire go_r_par = hi_q > pmid;

  wire covers = (lo_q <= s_v) && (hi_q >= e_v);
  wire go_l   = lo_q <= mid_v;
  wire is_q   = mode_q == ict_pkg::ModeQuery;
  wire [1:0] tag_op = (mode_q == ict_pkg::ModeAdd) ? ict_pkg::TagSet : ict_pkg::TagClear;
  logic [1:0] ptag_q, ptag_d;

  always_comb begin
    st_d = st_q; clr_d = clr_q; node_d = node_q; lvl_d = lvl_q;
    mode_d = mode_q; lo_d = lo_q; hi_d = hi_q; past_d = past_q;
    ans_d = ans_q; err_d = err_q; lcov_d = lcov_q;
    ptag_d = ptag_q;
    for (int i = 0; i < DW; i++) ph_d[i] = ph_q[i];
    we = 1'b0; waddr = node_q; wdata = 3'd0; raddr = node_q;
    case (st_q)
      StClr: begin
        we = 1'b1; waddr = clr_q[AW-1:0];
        clr_d = clr_q + 1'b1;
        if (clr_q == NodeCount - 1'b1) st_d = StIdle;
      end
      StIdle: begin
        if (start_i) begin
          mode_d = item_i.mode;
          past_d = item_i.right > Space;
          lo_d   = item_i.left[CoordBits-1:0];
          hi_d   = CoordBits'((item_i.right > Space ? Space : item_i.right) - 1'b1);
          err_d  = {1'b0, item_i.left} >= item_i.right;
          ans_d  = 1'b0;
          node_d = AW'(1); lvl_d = '0;
          if ({1'b0, item_i.left} >= item_i.right || item_i.mode == ict_pkg::ModeUnused ||
              {1'b0, item_i.left} >= Space) st_d = StDone;
          else begin
            ans_d = 1'b1;
            st_d = StVisit;
          end
        end
      end
      StVisit: st_d = StEval;
      StEval: begin
        if (covers) begin
          if (is_q) ans_d = ans_q & rdata[0];
          else begin
            we = 1'b1;
            wdata = {tag_op, tag_op == ict_pkg::TagSet};
          end
          st_d = StRet;
        end else begin
          ptag_d = rdata[2:1];
          st_d = (rdata[2:1] == ict_pkg::TagNone) ? StPushR : StPushL;
        end
      end
      StPushL: begin
        we = 1'b1; waddr = {node_q[AW-2:0], 1'b0};
        wdata = {ptag_q, ptag_q == ict_pkg::TagSet};
        st_d = StPushR;
      end
      StPushR: begin
        if (ptag_q != ict_pkg::TagNone) begin
          we = 1'b1; waddr = {node_q[AW-2:0], 1'b1};
          wdata = {ptag_q, ptag_q == ict_pkg::TagSet};
        end
        // own tag is dropped when the node is rebuilt on the way back
        if (go_l) begin
          ph_d[lvl_q] = 2'd0;
          node_d = {node_q[AW-2:0], 1'b0};
          lvl_d = lvl_q + 1'b1; st_d = StVisit;
        end else begin
          ph_d[lvl_q] = 2'd1;
          node_d = {node_q[AW-2:0], 1'b1};
          lvl_d = lvl_q + 1'b1; st_d = StVisit;
        end
      end
      StRdL: begin
        raddr = {node_q[AW-2:0], 1'b0}; st_d = StRdR;
      end
      StRdR: begin
        raddr = {node_q[AW-2:0], 1'b1}; lcov_d = rdata[0]; st_d = StWrN;
      end
      StWrN: begin
        // an untagged node always holds the AND of its children
        we = 1'b1;
        wdata = {ict_pkg::TagNone, lcov_q & rdata[0]};
        st_d = StRet;
      end
      StRet: begin
        if (lvl_q == '0) st_d = StDone;
        else begin
          node_d = node_q >> 1; lvl_d = lvl_q - 1'b1;
          if (ph_q[lvl_q - 1'b1] == 2'd0 && go_r_par && !(is_q && !ans_q)) begin
            ph_d[lvl_q - 1'b1] = 2'd1;
            node_d = {node_q[AW-1:1], 1'b1};
            lvl_d = lvl_q; st_d = StVisit;
          end else begin
            ph_d[lvl_q - 1'b1] = 2'd2;
            // rebuild parent: re-read children then write
            st_d = StRdL;
          end
        end
      end
      StDone: begin
        ans_d = is_q & ans_q & ~past_q & ~err_q;
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr; clr_q <= '0;
    end else begin
      st_q <= st_d; clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d; lvl_q <= lvl_d; mode_q <= mode_d; lo_q <= lo_d; hi_q <= hi_d;
    past_q <= past_d; ans_q <= ans_d; err_q <= err_d; lcov_q <= lcov_d;
    ptag_q <= ptag_d;
    for (int i = 0; i < DW; i++) ph_q[i] <= ph_d[i];
  end

  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= (st_q == StDone);
  end

  assign busy_o = (st_q != StIdle);
  assign done_o = done_q;
  assign result_o.answer = ans_q;
  assign result_o.error  = err_q;
endmodule
`default_nettype wire

[rtl/core/ict_checker.sv]
// Port-level checker for the interval coverage tracker, bound to the top level.
// Depends on ict_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ict_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start_i,
  input wire logic             busy_o,
  input wire logic             done_o,
  input wire ict_pkg::result_t result_o
);
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_err_ans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.error |-> !result_o.answer) else $error("answer on error");
  a_busy_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("accept without busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("done while busy");
endmodule

bind interval_coverage_tracker_core ict_checker u_ict_checker (.*);
`default_nettype wire

[tb/tb.sv]
// Testbench for interval_coverage_tracker_core: drives add/remove/query/unused words
// and checks each result against a behavioral coverage map. Depends on ict_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import ict_pkg::*;

  localparam int unsigned SpaceSize = 1024;
  localparam longint CycleLimit = 3_000_000;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start_i = 1'b0;
  item_t   item_i = '0;
  logic    busy_o;
  logic    done_o;
  result_t result_o;

  interval_coverage_tracker_core DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .item_i  (item_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Flat coverage map: a segment tree with lazy tags is observably the same.
  bit      covered_map [SpaceSize];
  result_t expected_results[$];
  int      fail_count = 0;
  longint  cycle_count = 0;

  // Compute the result of one word and update the coverage map.
  function automatic result_t apply_word(item_t w);
    result_t r;
    int hi;
    r = '0;
    if (w.left >= w.right) begin
      r.error = 1'b1;
      return r;
    end
    if (w.mode == ModeUnused) return r;
    hi = (w.right > SpaceSize) ? SpaceSize : w.right;
    case (w.mode)
      ModeAdd:    for (int p = w.left; p < hi; p++) covered_map[p] = 1'b1;
      ModeRemove: for (int p = w.left; p < hi; p++) covered_map[p] = 1'b0;
      default: begin
        r.answer = (w.right <= SpaceSize);
        for (int p = w.left; p < hi; p++) if (!covered_map[p]) r.answer = 1'b0;
      end
    endcase
    return r;
  endfunction

  // Check each strobed result against the oldest expectation.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && done_o) begin
      result_t exp_r;
      if (expected_results.size() == 0) begin
        $error("unexpected result answer=%0b error=%0b", result_o.answer, result_o.error);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (result_o.answer !== exp_r.answer) begin
          $error("answer: expected %0b actual %0b", exp_r.answer, result_o.answer);
          fail_count++;
        end
        if (result_o.error !== exp_r.error) begin
          $error("error: expected %0b actual %0b", exp_r.error, result_o.error);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      $display("[interval_coverage_tracker_core] ERROR");
      $finish;
    end
  end

  int burst_left = 0;

  // Send one word: raise start and hold it until the block takes the word.
  // Start stays high inside a burst and drops only for a gap.
  task automatic send_word(logic [1:0] mode, int left, int right);
    item_t w;
    w.mode = mode;
    w.left = left[9:0];
    w.right = right[10:0];
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end
    end
    burst_left--;
    start_i <= 1'b1;
    item_i <= w;
    do @(posedge clk_i); while (busy_o);
    expected_results.push_back(apply_word(w));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_word(ModeQuery, 0, 1024);
    send_word(ModeAdd, 0, 1024);
    send_word(ModeQuery, 0, 1024);
    send_word(ModeQuery, 1023, 1024);
    send_word(ModeQuery, 0, 1025);
    send_word(ModeQuery, 1023, 2047);
    send_word(ModeRemove, 511, 513);
    send_word(ModeQuery, 0, 512);
    send_word(ModeQuery, 510, 514);
    send_word(ModeAdd, 500, 2047);
    send_word(ModeQuery, 0, 1024);
    send_word(ModeRemove, 1023, 1500);
    send_word(ModeQuery, 1022, 1023);
    send_word(ModeAdd, 5, 5);
    send_word(ModeQuery, 1023, 0);
    send_word(ModeRemove, 700, 3);
    send_word(ModeUnused, 0, 1024);
    send_word(ModeUnused, 9, 2);
    send_word(ModeAdd, 1023, 2047);
    send_word(ModeQuery, 1023, 1024);
    send_word(ModeRemove, 0, 2047);
    send_word(ModeQuery, 0, 1);
  endtask

  // Pause until every pending result has come back, then add and query one interval.
  task automatic test_pause_drain();
    wait_drained();
    send_word(ModeAdd, 100, 200);
    send_word(ModeQuery, 100, 200);
  endtask

  function automatic logic [1:0] ModeLike(int k);
    return (k < 7) ? ModeAdd : (k < 11) ? ModeRemove : ModeQuery;
  endfunction

  task automatic test_random(int count);
    int l, r, k;
    logic [1:0] m;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 19);
      m = (k < 18) ? ModeLike(k) : 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0: begin l = $urandom_range(0, 1023); r = $urandom_range(0, 2047); end
        1: begin l = $urandom_range(0, 1023); r = l + $urandom_range(0, 1); end
        2: begin l = $urandom_range(900, 1023); r = $urandom_range(1000, 2047); end
        default: begin
          l = $urandom_range(0, 1000);
          r = l + 1 + $urandom_range(0, ($urandom_range(0, 3) == 0) ? 600 : 40);
        end
      endcase
      send_word(m, l, r);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_pause_drain();
    test_random(1500);
    wait_drained();
    repeat (300) @(negedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("[interval_coverage_tracker_core] OK");
    end else begin
      $display("[interval_coverage_tracker_core] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
